[design/rbr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_pkg
// shared constants for the raster to block reorder unit
// ----------------------------------------------------------------------------
package rbr_pkg;

    localparam int RBR_BLK         = 8;
    localparam int RBR_BLK_LOG     = 3;
    localparam int RBR_MAX_WIDTH   = 2048;
    localparam int RBR_MAX_HEIGHT  = 8192;

    localparam int RBR_PIX_W       = 8;
    localparam int RBR_BIDX_W      = 18;
    localparam int RBR_POS_W       = 6;
    localparam int RBR_BPR_W       = 9;
    localparam int RBR_BPC_W       = 11;
    localparam int RBR_CFG_IDX_W   = 2;
    localparam int RBR_CFG_DATA_W  = 11;

    // request kinds on the input side
    localparam logic RBR_OP_WRITE  = 1'b0;
    localparam logic RBR_OP_DRAIN  = 1'b1;

    // configuration register indexes
    localparam logic [RBR_CFG_IDX_W-1:0] RBR_REG_BPR = 2'd0;
    localparam logic [RBR_CFG_IDX_W-1:0] RBR_REG_BPC = 2'd1;

endpackage
`default_nettype wire

[design/rbr_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rbr_store
// single-port strip store, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module rbr_store
    import rbr_pkg::*;
#(
    parameter int DEPTH  = 2 * RBR_BLK * RBR_MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [ADDR_W-1:0]    addr,
    input  wire logic [RBR_PIX_W-1:0] wdata,
    output logic      [RBR_PIX_W-1:0] rdata
);

    logic [RBR_PIX_W-1:0] mem [DEPTH];
    logic [RBR_PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/raster_to_block_reorder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// raster_to_block_reorder_unit
// one channel of 8-bit raster pixels in, the same pixels out as 8x8 blocks
// ----------------------------------------------------------------------------
//  channel  dir  handshake            contents
//  s_       in   s_tvalid/s_tready    tdata pixel_in, tuser op
//  m_       out  m_tvalid/m_tready    tdata pixel/block_index/pos, tlast, tuser
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one request per cycle sustained while m_ accepts; each result passes the
//  strip store read stage and then the output register
//  the single store port takes either the pixel write or the drain read
//  synchronous active-low reset clears counters and bank flags, not the store
//  back-pressure on m_ holds the output and stops s_ once the pipe is full
// ----------------------------------------------------------------------------
module raster_to_block_reorder_unit
    import rbr_pkg::*;
#(
    parameter int MAX_WIDTH  = RBR_MAX_WIDTH,
    parameter int MAX_HEIGHT = RBR_MAX_HEIGHT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // pixel_in[7:0]
    input  wire logic [0:0]                s_tuser,   // op[0]

    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [31:0]                    m_tdata,   // pixel_out[7:0],
                                                      // block_index[25:8],
                                                      // pos_in_block[31:26]
    output logic                           m_tlast,   // last_in_block
    output logic [2:0]                     m_tuser,   // valid_res[0],
                                                      // last_of_image[1],
                                                      // rejected[2]

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [RBR_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [RBR_CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH     = 2 * RBR_BLK * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int MAX_BPR   = MAX_WIDTH / RBR_BLK;
    localparam int MAX_BPC   = MAX_HEIGHT / RBR_BLK;
    localparam int BCOL_W    = (MAX_BPR > 1) ? $clog2(MAX_BPR) : 1;
    localparam int STRIP_W   = (MAX_BPC > 1) ? $clog2(MAX_BPC) : 1;
    localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(RBR_BLK * MAX_WIDTH);
    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);

    typedef struct packed {
        logic                  drain;
        logic                  valid_res;
        logic [RBR_BIDX_W-1:0] block_index;
        logic [RBR_POS_W-1:0]  pos_in_block;
        logic                  last_in_block;
        logic                  last_of_image;
        logic                  rejected;
    } rbr_meta_t;

    // configuration
    logic [RBR_BPR_W-1:0] bpr_reg;
    logic [RBR_BPC_W-1:0] bpc_reg;
    logic [RBR_BPR_W-1:0] eff_bpr;
    logic [RBR_BPC_W-1:0] eff_bpc;
    logic                 cfg_fire;
    logic                 restart;

    // frame state
    logic [1:0]           bank_full_reg,  bank_full_next;
    logic                 wbank_reg,      wbank_next;
    logic [COL_W-1:0]     wcol_reg,       wcol_next;
    logic [ROW_W-1:0]     wrow_reg,       wrow_next;
    logic                 wdone_reg,      wdone_next;
    logic                 rbank_reg,      rbank_next;
    logic [BCOL_W-1:0]    rbcol_reg,      rbcol_next;
    logic [RBR_POS_W-1:0] rpos_reg,       rpos_next;
    logic [STRIP_W-1:0]   rstrip_reg,     rstrip_next;
    logic                 rdone_reg,      rdone_next;

    // pipe
    logic                 p1_valid_reg;
    rbr_meta_t            p1_reg;
    rbr_meta_t            meta_next;
    logic                 out_valid_reg;
    rbr_meta_t            out_reg;
    logic [RBR_PIX_W-1:0] out_pix_reg;
    logic                 p1_move;
    logic                 in_fire;

    // store access
    logic                 st_en;
    logic                 st_we;
    logic [ADDR_W-1:0]    st_addr;
    logic [RBR_PIX_W-1:0] st_rdata;

    logic                 wr_rej;
    logic                 wr_last_col;
    logic                 wr_last_row;
    logic                 rd_ok;
    logic                 rd_last_blk;
    logic                 rd_last_col;
    logic                 rd_last_strip;
    logic [31:0]          bidx_full;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && (cfg_index == RBR_REG_BPR || cfg_index == RBR_REG_BPC);

    always_comb begin
        if (bpr_reg == '0) begin
            eff_bpr = RBR_BPR_W'(1);
        end else if (32'(bpr_reg) > MAX_BPR) begin
            eff_bpr = RBR_BPR_W'(MAX_BPR);
        end else begin
            eff_bpr = bpr_reg;
        end
        if (bpc_reg == '0) begin
            eff_bpc = RBR_BPC_W'(1);
        end else if (32'(bpc_reg) > MAX_BPC) begin
            eff_bpc = RBR_BPC_W'(MAX_BPC);
        end else begin
            eff_bpc = bpc_reg;
        end
    end

    assign p1_move  = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_move;
    assign in_fire  = s_tvalid && s_tready;

    assign wr_rej        = wdone_reg || bank_full_reg[wbank_reg];
    assign wr_last_col   = (32'(wcol_reg) + 32'd1) >= (32'(eff_bpr) << RBR_BLK_LOG);
    assign wr_last_row   = (32'(wrow_reg) + 32'd1) >= (32'(eff_bpc) << RBR_BLK_LOG);
    assign rd_ok         = !rdone_reg && bank_full_reg[rbank_reg];
    assign rd_last_blk   = (rpos_reg == '1);
    assign rd_last_col   = (32'(rbcol_reg) + 32'd1) >= 32'(eff_bpr);
    assign rd_last_strip = (32'(rstrip_reg) + 32'd1) >= 32'(eff_bpc);
    assign bidx_full     = 32'(rstrip_reg) * 32'(eff_bpr) + 32'(rbcol_reg);

    always_comb begin
        bank_full_next = bank_full_reg;
        wbank_next     = wbank_reg;
        wcol_next      = wcol_reg;
        wrow_next      = wrow_reg;
        wdone_next     = wdone_reg;
        rbank_next     = rbank_reg;
        rbcol_next     = rbcol_reg;
        rpos_next      = rpos_reg;
        rstrip_next    = rstrip_reg;
        rdone_next     = rdone_reg;
        meta_next      = '0;
        st_en          = 1'b0;
        st_we          = 1'b0;
        st_addr        = '0;

        if (in_fire) begin
            unique case (s_tuser[0])
                RBR_OP_WRITE: begin
                    meta_next.rejected = wr_rej;
                    st_addr = (wbank_reg ? BANK_BASE : '0)
                            + ADDR_W'(wrow_reg[RBR_BLK_LOG-1:0]) * ROW_PITCH
                            + ADDR_W'(wcol_reg);
                    if (!wr_rej) begin
                        st_en = 1'b1;
                        st_we = 1'b1;
                        if (wr_last_col) begin
                            wcol_next = '0;
                            if (wrow_reg[RBR_BLK_LOG-1:0] == '1) begin
                                bank_full_next[wbank_reg] = 1'b1;
                                wbank_next = !wbank_reg;
                            end
                            if (wr_last_row) begin
                                wdone_next = 1'b1;
                            end else begin
                                wrow_next = wrow_reg + ROW_W'(1);
                            end
                        end else begin
                            wcol_next = wcol_reg + COL_W'(1);
                        end
                    end
                end
                RBR_OP_DRAIN: begin
                    st_addr = (rbank_reg ? BANK_BASE : '0)
                            + ADDR_W'(rpos_reg[RBR_POS_W-1:RBR_BLK_LOG]) * ROW_PITCH
                            + ADDR_W'({rbcol_reg, rpos_reg[RBR_BLK_LOG-1:0]});
                    if (rd_ok) begin
                        st_en                   = 1'b1;
                        meta_next.drain         = 1'b1;
                        meta_next.valid_res     = 1'b1;
                        meta_next.block_index   = bidx_full[RBR_BIDX_W-1:0];
                        meta_next.pos_in_block  = rpos_reg;
                        meta_next.last_in_block = rd_last_blk;
                        meta_next.last_of_image = rd_last_blk && rd_last_col && rd_last_strip;
                        if (!rd_last_blk) begin
                            rpos_next = rpos_reg + RBR_POS_W'(1);
                        end else begin
                            rpos_next = '0;
                            if (!rd_last_col) begin
                                rbcol_next = rbcol_reg + BCOL_W'(1);
                            end else begin
                                rbcol_next = '0;
                                bank_full_next[rbank_reg] = 1'b0;
                                rbank_next = !rbank_reg;
                                if (rd_last_strip) begin
                                    rdone_next = 1'b1;
                                end else begin
                                    rstrip_next = rstrip_reg + STRIP_W'(1);
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpr_reg       <= RBR_BPR_W'(1);
            bpc_reg       <= RBR_BPC_W'(1);
            bank_full_reg <= '0;
            wbank_reg     <= 1'b0;
            wcol_reg      <= '0;
            wrow_reg      <= '0;
            wdone_reg     <= 1'b0;
            rbank_reg     <= 1'b0;
            rbcol_reg     <= '0;
            rpos_reg      <= '0;
            rstrip_reg    <= '0;
            rdone_reg     <= 1'b0;
        end else if (restart) begin
            if (cfg_index == RBR_REG_BPR) begin
                bpr_reg <= cfg_data[RBR_BPR_W-1:0];
            end else begin
                bpc_reg <= cfg_data[RBR_BPC_W-1:0];
            end
            bank_full_reg <= '0;
            wbank_reg     <= 1'b0;
            wcol_reg      <= '0;
            wrow_reg      <= '0;
            wdone_reg     <= 1'b0;
            rbank_reg     <= 1'b0;
            rbcol_reg     <= '0;
            rpos_reg      <= '0;
            rstrip_reg    <= '0;
            rdone_reg     <= 1'b0;
        end else begin
            bank_full_reg <= bank_full_next;
            wbank_reg     <= wbank_next;
            wcol_reg      <= wcol_next;
            wrow_reg      <= wrow_next;
            wdone_reg     <= wdone_next;
            rbank_reg     <= rbank_next;
            rbcol_reg     <= rbcol_next;
            rpos_reg      <= rpos_next;
            rstrip_reg    <= rstrip_next;
            rdone_reg     <= rdone_next;
        end
    end

    // pipe control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_move) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pipe payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p1_reg <= meta_next;
        end
        if (p1_move) begin
            out_reg     <= p1_reg;
            out_pix_reg <= p1_reg.drain ? st_rdata : '0;
        end
    end

    rbr_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .en    (st_en),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (s_tdata),
        .rdata (st_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.pos_in_block, out_reg.block_index, out_pix_reg};
    assign m_tlast  = out_reg.last_in_block;
    assign m_tuser  = {out_reg.rejected, out_reg.last_of_image, out_reg.valid_res};

    // a write with both banks full is always dropped
    a_full_rejects: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser[0] == RBR_OP_WRITE && bank_full_reg == 2'b11 && !restart)
        |=> p1_reg.rejected)
        else $error("write accepted with both banks full");

    // last pixel of the image closes a block
    a_image_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tuser[0]))
        else $error("image end outside block end");

    // a drained pixel is never also a drop
    a_valid_not_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_reg.valid_res) |-> (!p1_reg.rejected && p1_reg.drain))
        else $error("drained pixel flagged as dropped");

endmodule
`default_nettype wire
